FILE: sv/lrul_pkg.sv
// Shared types and constants for the LRU recency list.
package lrul_pkg;

	localparam int KEY_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef logic signed [KEY_W-1:0] key_t;

	// Per-cell control from the list controller
	typedef struct packed {
		logic load;     // take the neighbor's key this cycle
		logic in_list;  // cell position lies below the fill count
	} cell_ctrl_t;

endpackage

FILE: sv/lrul_cell.sv
// One recency list cell: holds a key, compares it, shifts from its neighbor.
module lrul_cell (
	input  logic                clk,
	input  lrul_pkg::cell_ctrl_t ctrl,
	input  lrul_pkg::key_t      prev_key,
	input  lrul_pkg::key_t      req_key,
	output lrul_pkg::key_t      cell_key,
	output logic                match
);

	lrul_pkg::key_t key_q;

	// Entry content is undefined until first written; no reset
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= prev_key;
		end
	end

	assign cell_key = key_q;
	assign match    = ctrl.in_list && (key_q == req_key);

endmodule

FILE: sv/lru_recency_list_unit.sv
// Top level of the LRU recency list: a row of key cells plus list control.
// A request accepted in one cycle gives its result, marked by done, in the next cycle.
// One request per cycle; busy stays low, since the cell row compares all keys
// in parallel and shifts in the same cycle, and the result register frees the list at once.
// Reset: arst_n clears fill count, capacity (to 10) and done; cell keys are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_recency_list_unit #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  lrul_pkg::key_t                  key,
	input  logic                            cfg_we,
	input  logic [lrul_pkg::CAP_W-1:0]      cfg_wdata,
	output logic                            done,
	output logic                            hit,
	output logic                            evict_valid,
	output lrul_pkg::key_t                  evicted_key,
	output logic [$clog2(DEPTH+1)-1:0]      occupancy
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (OCC_W > lrul_pkg::CAP_W) ? OCC_W : lrul_pkg::CAP_W;
	localparam logic [OCC_W-1:0] LAST_IDX = OCC_W'(DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

	// Configuration and list state
	logic [lrul_pkg::CAP_W-1:0] capacity_q;
	logic [OCC_W-1:0]           fill_q;

	// Result registers
	logic                 done_q;
	logic                 hit_q;
	logic                 evict_valid_q;
	lrul_pkg::key_t       evicted_key_q;
	logic [OCC_W-1:0]     occupancy_q;

	// Cell row wiring
	lrul_pkg::key_t       cell_key [DEPTH];
	lrul_pkg::cell_ctrl_t cell_ctrl [DEPTH];
	logic [DEPTH-1:0]     match;

	// Control decode
	logic                 accept;
	logic [CMP_W-1:0]     cap_raw;
	logic [CMP_W-1:0]     cap_eff;
	logic                 hit_any;
	logic [OCC_W-1:0]     hit_pos;
	logic                 full;
	logic [OCC_W-1:0]     upto_raw;
	logic [OCC_W-1:0]     upto;
	lrul_pkg::key_t       evk;
	logic [OCC_W-1:0]     fill_next;

	// The list never blocks: the whole update is registered together
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Capacity zero acts as one; anything above the cell count saturates to it
	always_comb begin
		cap_raw = CMP_W'(capacity_q);
		if (cap_raw == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_raw > DEPTH_C) begin
			cap_eff = DEPTH_C;
		end else begin
			cap_eff = cap_raw;
		end
	end

	// Match nearest the front wins; scan from the tail so the lowest index is kept
	always_comb begin
		hit_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_pos = OCC_W'(i);
			end
		end
	end

	assign hit_any = |match;
	assign full    = (CMP_W'(fill_q) >= cap_eff) && (fill_q != '0);

	// Last cell that takes its neighbor's key: on a hit the matching cell,
	// on an eviction the tail cell, otherwise the first free cell
	always_comb begin
		if (hit_any) begin
			upto_raw = hit_pos;
		end else if (full) begin
			upto_raw = fill_q - OCC_W'(1);
		end else begin
			upto_raw = fill_q;
		end
		upto = (upto_raw > LAST_IDX) ? LAST_IDX : upto_raw;
	end

	// Pick the tail key for eviction
	always_comb begin
		evk = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (OCC_W'(i) == fill_q - OCC_W'(1)) begin
				evk = cell_key[i];
			end
		end
	end

	assign fill_next = (!hit_any && !full) ? fill_q + OCC_W'(1) : fill_q;

	// Per-cell control: shift the front part of the row down by one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctrl[i].load    = accept && (OCC_W'(i) <= upto);
			cell_ctrl[i].in_list = OCC_W'(i) < fill_q;
		end
	end

	// Cell row: cell 0 takes the request key, each other cell its front neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		lrul_pkg::key_t prev_key;
		if (g == 0) begin : g_head
			assign prev_key = key;
		end else begin : g_body
			assign prev_key = cell_key[g-1];
		end
		lrul_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[g]),
			.prev_key (prev_key),
			.req_key  (key),
			.cell_key (cell_key[g]),
			.match    (match[g])
		);
	end

	// Hold capacity until rewritten; advance fill count per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lrul_pkg::CAP_RESET;
			fill_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				fill_q <= fill_next;
			end
			done_q <= accept;
		end
	end

	// Result payload: capture on each request
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q         <= hit_any;
			evict_valid_q <= !hit_any && full;
			evicted_key_q <= (!hit_any && full) ? evk : '0;
			occupancy_q   <= fill_next;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign evict_valid = evict_valid_q;
	assign evicted_key = evicted_key_q;
	assign occupancy   = occupancy_q;

	// Checks
	a_occ_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy != '0)
		else $error("result reports an empty list");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evict_valid)
		else $error("hit and eviction on the same request");

	a_evk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evict_valid |-> evicted_key == '0)
		else $error("evicted key not zero without eviction");

	a_done_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result without a request");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= DEPTH_C)
		else $error("fill count exceeds cell count");

	a_occ_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy == fill_q)
		else $error("reported occupancy differs from fill count");

endmodule
